FILE: hw/rtl/lkvc_pkg.sv
// Shared constants, types and codes of the LRU key-value cache.
package lkvc_pkg;

  localparam int ENTRIES     = 8;
  localparam int KEY_BITS    = 32;
  localparam int DATA_W      = 32;
  localparam int IN_KEY_W    = 32;
  localparam int CAP_CFG_W   = 4;
  localparam int COUNT_OUT_W = 4;
  localparam int RESET_CAPACITY = 8;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int COUNT_W = $clog2(ENTRIES + 1);
  localparam int CAP_W   = (COUNT_W > CAP_CFG_W) ? COUNT_W : CAP_CFG_W;
  localparam int KEY_W   = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PROMOTE,
    CMD_INSERT
  } cmd_kind_t;

  // Lookup context broadcast to every cell while a request walks the chain.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             evict;
    logic [CAP_W-1:0] cap_m1;
  } srch_t;

  // Token handed from cell to cell; it gathers the lookup result.
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic [DATA_W-1:0] hit_value;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              mru_found;
    logic [KEY_W-1:0]  mru_key;
  } tok_t;

  // Update broadcast to every cell in the apply cycle.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  slot;
    logic [RANK_W-1:0] rank;
    logic              write_en;
    logic              evict;
    logic [CAP_W-1:0]  cap_m1;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

FILE: hw/rtl/lkvc_if.sv
// Request, response and configuration channel interfaces of the cache.
interface lkvc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] lookup_key;
  logic signed [31:0] write_value;

  modport source (output valid, opcode, lookup_key, write_value, input ready);
  modport sink   (input valid, opcode, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic signed [31:0] read_value;
  logic        evicted;
  logic [31:0] recent_key;
  logic        recent_valid;
  logic [3:0]  entry_count;

  modport source (output valid, hit, read_value, evicted, recent_key, recent_valid,
                  entry_count, input ready);
  modport sink   (input valid, hit, read_value, evicted, recent_key, recent_valid,
                  entry_count, output ready);
endinterface

interface lkvc_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

FILE: hw/rtl/lkvc_cell.sv
// One cache entry: key, value, valid and recency rank, with its link in the lookup chain.
module lkvc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lkvc_pkg::IDX_W-1:0]  cell_idx,
  input  lkvc_pkg::srch_t             srch,
  input  lkvc_pkg::tok_t              tok_in,
  output lkvc_pkg::tok_t              tok_out,
  input  lkvc_pkg::cmd_t              cmd,
  output logic                        entry_valid
);

  logic                              valid;
  logic [lkvc_pkg::KEY_W-1:0]        key;
  logic [lkvc_pkg::DATA_W-1:0]       value;
  logic [lkvc_pkg::RANK_W-1:0]       rank;
  lkvc_pkg::tok_t                    tok_next;
  logic                              match;
  logic                              free_here;
  logic                              is_slot;
  logic                              aged_out;

  assign match     = valid && (key == srch.key);
  assign free_here = !valid ||
                     (srch.evict && (lkvc_pkg::CAP_W'(rank) >= srch.cap_m1));
  assign is_slot   = (cmd.slot == cell_idx);
  assign aged_out  = cmd.evict && (lkvc_pkg::CAP_W'(rank) >= cmd.cap_m1);

  // The first cell along the chain that qualifies claims each token field.
  always_comb begin
    tok_next = tok_in;
    if (match && !tok_in.hit) begin
      tok_next.hit       = 1'b1;
      tok_next.hit_idx   = cell_idx;
      tok_next.hit_rank  = rank;
      tok_next.hit_value = value;
    end
    if (free_here && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = cell_idx;
    end
    if (valid && (rank == '0) && !tok_in.mru_found) begin
      tok_next.mru_found = 1'b1;
      tok_next.mru_key   = key;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      case (cmd.kind)
        lkvc_pkg::CMD_PROMOTE: begin
          if (is_slot) begin
            rank <= '0;
            if (cmd.write_en) begin
              value <= cmd.value;
            end
          end else if (valid && (rank < cmd.rank)) begin
            rank <= rank + lkvc_pkg::RANK_W'(1);
          end
        end
        lkvc_pkg::CMD_INSERT: begin
          if (is_slot) begin
            valid <= 1'b1;
            key   <= cmd.key;
            value <= cmd.value;
            rank  <= '0;
          end else if (valid) begin
            if (aged_out) begin
              valid <= 1'b0;
              rank  <= '0;
            end else begin
              rank <= rank + lkvc_pkg::RANK_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign entry_valid = valid;

endmodule

FILE: hw/rtl/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key-value cache.
//
//   channel | dir | fields
//   req     | in  | opcode, lookup_key, write_value
//   rsp     | out | hit, read_value, evicted, recent_key, recent_valid, entry_count
//   cfg     | in  | capacity (always ready)
//
// A request is accepted, then its lookup token walks the cell chain one cell per cycle
// in the search state, and then the apply state updates the cells.
// The result sits in an output register; the next request is accepted meanwhile and
// its update cycle holds until the pending result is taken.
// Reset clears every valid bit and rank, the occupancy, and sets capacity to 8.
module lru_key_value_cache_top (
  input  logic       clk,
  input  logic       rst,
  lkvc_req_if.sink   req,
  lkvc_rsp_if.source rsp,
  lkvc_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY
  } state_t;

  state_t                              state;
  logic [lkvc_pkg::IDX_W-1:0]          cnt;
  logic [lkvc_pkg::CAP_CFG_W-1:0]      capacity;
  logic [lkvc_pkg::COUNT_W-1:0]        occ;
  logic                                req_op;
  logic [lkvc_pkg::KEY_W-1:0]          req_key;
  logic [lkvc_pkg::DATA_W-1:0]         req_value;

  logic                                out_valid;
  logic                                out_hit;
  logic [lkvc_pkg::DATA_W-1:0]         out_read_value;
  logic                                out_evicted;
  logic [lkvc_pkg::IN_KEY_W-1:0]       out_recent_key;
  logic                                out_recent_valid;
  logic [lkvc_pkg::COUNT_OUT_W-1:0]    out_entry_count;

  logic [lkvc_pkg::CAP_W-1:0]          cap_eff;
  logic [lkvc_pkg::CAP_W-1:0]          cap_raw;
  logic                                evict_now;
  lkvc_pkg::srch_t                     srch;
  lkvc_pkg::cmd_t                      cmd;
  lkvc_pkg::tok_t                      tok_link [0:lkvc_pkg::ENTRIES];
  lkvc_pkg::tok_t                      tok_end;
  logic [lkvc_pkg::ENTRIES-1:0]        valid_vec;
  logic                                go;
  logic                                is_write;
  logic                                insert;
  logic [lkvc_pkg::COUNT_W-1:0]        occ_next;
  logic [lkvc_pkg::KEY_W-1:0]          recent_next;

  assign cap_raw = lkvc_pkg::CAP_W'(capacity);

  always_comb begin
    if (cap_raw == '0) begin
      cap_eff = lkvc_pkg::CAP_W'(1);
    end else if (cap_raw > lkvc_pkg::CAP_W'(lkvc_pkg::ENTRIES)) begin
      cap_eff = lkvc_pkg::CAP_W'(lkvc_pkg::ENTRIES);
    end else begin
      cap_eff = cap_raw;
    end
  end

  assign evict_now   = lkvc_pkg::CAP_W'(occ) >= cap_eff;
  assign srch.key    = req_key;
  assign srch.evict  = evict_now;
  assign srch.cap_m1 = cap_eff - lkvc_pkg::CAP_W'(1);

  assign tok_link[0] = '0;

  for (genvar i = 0; i < lkvc_pkg::ENTRIES; i++) begin : g_cell
    lkvc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_idx    (lkvc_pkg::IDX_W'(i)),
      .srch        (srch),
      .tok_in      (tok_link[i]),
      .tok_out     (tok_link[i+1]),
      .cmd         (cmd),
      .entry_valid (valid_vec[i])
    );
  end

  assign tok_end  = tok_link[lkvc_pkg::ENTRIES];
  assign go       = (state == S_APPLY) && (!out_valid || rsp.ready);
  assign is_write = (req_op == lkvc_pkg::OP_WRITE);
  // A write of a new key always finds a slot: either one is free or eviction frees one.
  assign insert   = is_write && !tok_end.hit;

  always_comb begin
    cmd          = '0;
    cmd.kind     = lkvc_pkg::CMD_NONE;
    cmd.key      = req_key;
    cmd.value    = req_value;
    cmd.evict    = evict_now;
    cmd.cap_m1   = srch.cap_m1;
    cmd.write_en = is_write;
    cmd.rank     = tok_end.hit_rank;
    if (go) begin
      if (tok_end.hit) begin
        cmd.kind = lkvc_pkg::CMD_PROMOTE;
        cmd.slot = tok_end.hit_idx;
      end else if (is_write) begin
        cmd.kind = lkvc_pkg::CMD_INSERT;
        cmd.slot = tok_end.free_idx;
      end
    end
  end

  always_comb begin
    occ_next = occ;
    if (insert) begin
      occ_next = evict_now ? lkvc_pkg::COUNT_W'(cap_eff) : occ + lkvc_pkg::COUNT_W'(1);
    end
    if (tok_end.hit || insert) begin
      recent_next = req_key;
    end else if (tok_end.mru_found) begin
      recent_next = tok_end.mru_key;
    end else begin
      recent_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      capacity  <= lkvc_pkg::CAP_CFG_W'(lkvc_pkg::RESET_CAPACITY);
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_op    <= req.opcode;
            req_key   <= req.lookup_key[lkvc_pkg::KEY_W-1:0];
            req_value <= req.write_value;
            cnt       <= '0;
            state     <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (cnt == lkvc_pkg::IDX_W'(lkvc_pkg::ENTRIES - 1)) begin
            state <= S_APPLY;
          end else begin
            cnt <= cnt + lkvc_pkg::IDX_W'(1);
          end
        end
        S_APPLY: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (go) begin
        occ              <= occ_next;
        out_valid        <= 1'b1;
        out_hit          <= tok_end.hit;
        out_read_value   <= (!is_write && tok_end.hit) ? tok_end.hit_value : '1;
        out_evicted      <= insert && evict_now;
        out_recent_key   <= lkvc_pkg::IN_KEY_W'(recent_next);
        out_recent_valid <= (occ_next != '0);
        out_entry_count  <= lkvc_pkg::COUNT_OUT_W'(occ_next);
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.read_value   = out_read_value;
  assign rsp.evicted      = out_evicted;
  assign rsp.recent_key   = out_recent_key;
  assign rsp.recent_valid = out_recent_valid;
  assign rsp.entry_count  = out_entry_count;

  // The occupancy counter tracks the cells' valid bits whenever no update is pending.
  a_occ_matches_cells: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(valid_vec) == int'(occ)))
    else $error("occupancy disagrees with cell valid bits");

  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(occ) <= lkvc_pkg::ENTRIES)
    else $error("occupancy above entry count");

  a_hit_cell_valid: assert property (@(posedge clk) disable iff (rst)
    (go && tok_end.hit) |-> valid_vec[tok_end.hit_idx])
    else $error("hit reported on an empty cell");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (rst)
    (go && insert) |-> tok_end.free_found)
    else $error("insert without a free slot");

  a_evict_fills_to_cap: assert property (@(posedge clk) disable iff (rst)
    (go && insert && evict_now) |=> (lkvc_pkg::CAP_W'(occ) == $past(cap_eff)))
    else $error("eviction left wrong occupancy");

endmodule
